### hdl/fmkc_pkg.sv
// Shared constants and types for the fan mode key controller.
`default_nettype none

package fmkc_pkg;

  typedef enum logic [1:0] {
    ModeOff   = 2'd0,
    ModeHalf  = 2'd1,
    ModeFull  = 2'd2,
    ModeBurst = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DriveOff  = 2'd0,
    DriveHalf = 2'd1,
    DriveFull = 2'd2
  } drive_e;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegDebounceLimit = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIdleLockMs    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBurstOn       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBurstPeriod   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSleepIdleMs   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCoarseDivider = 3'd5;

  localparam int unsigned TimerBitsDefault = 16;

  localparam logic [7:0]  DebounceLimitRst = 8'd15;
  localparam logic [15:0] IdleLockMsRst    = 16'd5000;
  localparam logic [15:0] BurstOnRst       = 16'd6000;
  localparam logic [15:0] BurstPeriodRst   = 16'd9000;
  localparam logic [15:0] SleepIdleMsRst   = 16'd5000;
  localparam logic [7:0]  CoarseDividerRst = 8'd10;

endpackage

`default_nettype wire

### hdl/fan_mode_key_controller.sv
// Top level of the fan mode key controller: debounce, mode stepping, lock, burst, sleep.
//
// Each request is one 1 ms tick carrying the raw active-low key level. A request is
// taken every clock cycle while the result register is empty or being drained, and
// its result appears in the result register in the cycle after acceptance, so the
// block sustains one tick per cycle while results are drained. The state update
// between the accepted request and the result register is combinational.
// Configuration writes are always accepted and take effect for the next tick.
`default_nettype none

module fan_mode_key_controller
  import fmkc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               key_level_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [1:0]         fan_mode_o,
  output      logic [1:0]         drive_level_o,
  output      logic               led_pin_o,
  output      logic               locked_out_o,
  output      logic               sleep_request_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  localparam int unsigned CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TMax = {TIMER_BITS{1'b1}};

  logic [7:0]  debounce_limit_q, coarse_divider_q;
  logic [15:0] idle_lock_ms_q, burst_on_q, burst_period_q, sleep_idle_ms_q;

  logic [7:0]            tick_div_q, tick_div_d;
  logic [7:0]            db_timer_q, db_timer_d;
  logic                  stable_key_q, stable_key_d;
  logic                  press_held_q, press_held_d;
  mode_e                 mode_q, mode_d;
  mode_e                 saved_mode_q, saved_mode_d;
  logic                  lock_q, lock_d;
  logic [TIMER_BITS-1:0] idle_timer_q, idle_timer_d;
  logic [TIMER_BITS-1:0] burst_timer_q, burst_timer_d;
  logic                  burst_active_q, burst_active_d;
  logic [TIMER_BITS-1:0] off_timer_q, off_timer_d;

  drive_e drive_d;
  logic   sleep_d;
  logic   press;
  logic   in_fire;

  logic       out_valid_q;
  logic [1:0] fan_mode_q, drive_level_q;
  logic       led_pin_q, locked_out_q, sleep_request_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_limit_q <= DebounceLimitRst;
      idle_lock_ms_q   <= IdleLockMsRst;
      burst_on_q       <= BurstOnRst;
      burst_period_q   <= BurstPeriodRst;
      sleep_idle_ms_q  <= SleepIdleMsRst;
      coarse_divider_q <= CoarseDividerRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDebounceLimit: debounce_limit_q <= cfg_data_i[7:0];
        RegIdleLockMs:    idle_lock_ms_q   <= cfg_data_i;
        RegBurstOn:       burst_on_q       <= cfg_data_i;
        RegBurstPeriod:   burst_period_q   <= cfg_data_i;
        RegSleepIdleMs:   sleep_idle_ms_q  <= cfg_data_i;
        RegCoarseDivider: coarse_divider_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0] td_inc;
    logic       down;
    tick_div_d     = tick_div_q;
    db_timer_d     = db_timer_q;
    stable_key_d   = stable_key_q;
    press_held_d   = press_held_q;
    mode_d         = mode_q;
    saved_mode_d   = saved_mode_q;
    lock_d         = lock_q;
    idle_timer_d   = idle_timer_q;
    burst_timer_d  = burst_timer_q;
    burst_active_d = burst_active_q;
    off_timer_d    = off_timer_q;
    press          = 1'b0;
    sleep_d        = 1'b0;
    down           = 1'b0;

    // time base
    td_inc = tick_div_q + 8'd1;
    if (td_inc >= coarse_divider_q) begin
      tick_div_d = '0;
      if (burst_timer_q != TMax) burst_timer_d = burst_timer_q + 1'b1;
    end else begin
      tick_div_d = td_inc;
    end
    if (db_timer_q != 8'hFF) db_timer_d = db_timer_q + 8'd1;
    if (off_timer_q != TMax) off_timer_d = off_timer_q + 1'b1;
    if (mode_q != ModeOff && !lock_q) begin
      if (idle_timer_q != TMax) idle_timer_d = idle_timer_q + 1'b1;
    end else begin
      idle_timer_d = '0;
    end

    // debounce, one-shot press
    if (key_level_i != stable_key_q) begin
      if (db_timer_d > debounce_limit_q) begin
        stable_key_d = key_level_i;
        db_timer_d   = '0;
      end
    end else begin
      down         = !stable_key_q;
      db_timer_d   = '0;
      press        = down && !press_held_q;
      press_held_d = down;
    end

    if (press) begin
      if (!lock_q) begin
        if (saved_mode_q == ModeOff) begin
          mode_d = mode_e'(mode_q + 2'd1);
        end else begin
          mode_d        = saved_mode_q;
          saved_mode_d  = ModeOff;
          burst_timer_d = '0;
        end
      end else begin
        lock_d       = 1'b0;
        saved_mode_d = mode_q;
        mode_d       = ModeOff;
      end
      idle_timer_d = '0;
    end

    if (CmpW'(idle_timer_d) > CmpW'(idle_lock_ms_q)) begin
      idle_timer_d = '0;
      lock_d       = 1'b1;
    end

    // intermittent phase
    if (mode_d == ModeBurst) begin
      if (CmpW'(burst_timer_d) < CmpW'(burst_on_q)) begin
        burst_active_d = 1'b1;
      end else if (CmpW'(burst_timer_d) < CmpW'(burst_period_q)) begin
        burst_active_d = 1'b0;
      end else begin
        burst_timer_d = '0;
      end
    end else begin
      burst_timer_d = '0;
    end

    case (mode_d)
      ModeOff:  drive_d = DriveOff;
      ModeHalf: drive_d = DriveHalf;
      ModeFull: drive_d = DriveFull;
      default:  drive_d = burst_active_d ? DriveFull : DriveOff;
    endcase

    if (mode_d != ModeOff) off_timer_d = '0;
    if (CmpW'(off_timer_d) > CmpW'(sleep_idle_ms_q)) begin
      off_timer_d = '0;
      sleep_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q     <= '0;
      db_timer_q     <= '0;
      stable_key_q   <= 1'b0;
      press_held_q   <= 1'b0;
      mode_q         <= ModeOff;
      saved_mode_q   <= ModeOff;
      lock_q         <= 1'b0;
      idle_timer_q   <= '0;
      burst_timer_q  <= '0;
      burst_active_q <= 1'b0;
      off_timer_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        tick_div_q     <= tick_div_d;
        db_timer_q     <= db_timer_d;
        stable_key_q   <= stable_key_d;
        press_held_q   <= press_held_d;
        mode_q         <= mode_d;
        saved_mode_q   <= saved_mode_d;
        lock_q         <= lock_d;
        idle_timer_q   <= idle_timer_d;
        burst_timer_q  <= burst_timer_d;
        burst_active_q <= burst_active_d;
        off_timer_q    <= off_timer_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fan_mode_q      <= mode_d;
      drive_level_q   <= drive_d;
      led_pin_q       <= (mode_d == ModeOff);
      locked_out_q    <= lock_d;
      sleep_request_q <= sleep_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fan_mode_o      = fan_mode_q;
  assign drive_level_o   = drive_level_q;
  assign led_pin_o       = led_pin_q;
  assign locked_out_o    = locked_out_q;
  assign sleep_request_o = sleep_request_q;

endmodule

`default_nettype wire

### hdl/fmkc_checker.sv
// Port-level assertions for the fan mode key controller, bound to the top level.
`default_nettype none

module fmkc_checker
  import fmkc_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] fan_mode_o,
  input wire logic [1:0] drive_level_o,
  input wire logic       led_pin_o,
  input wire logic       sleep_request_o
);

  a_led_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (led_pin_o == (fan_mode_o == ModeOff)))
    else $error("led does not track off mode");

  a_drive_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((fan_mode_o == ModeHalf) == (drive_level_o == DriveHalf)) &&
                    (fan_mode_o != ModeFull || drive_level_o == DriveFull) &&
                    (fan_mode_o != ModeOff || drive_level_o == DriveOff))
    else $error("drive level disagrees with mode");

  a_sleep_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sleep_request_o) |-> (fan_mode_o == ModeOff))
    else $error("sleep request while fan is on");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(fan_mode_o) && $stable(drive_level_o)))
    else $error("stalled result changed");

endmodule

bind fan_mode_key_controller fmkc_checker u_fmkc_checker (.*);

`default_nettype wire
